### rtl/etr_pkg.sv
// shared types and constants for the echo trimmed-mean ranger
`default_nettype none
package etr_pkg;

    typedef logic [2:0] status_t;

    localparam status_t ST_PENDING = 3'd0;
    localparam status_t ST_NO_ECHO = 3'd1;
    localparam status_t ST_SPREAD  = 3'd2;
    localparam status_t ST_SAFE    = 3'd3;
    localparam status_t ST_CLOSE   = 3'd4;
    localparam status_t ST_BELOW   = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_NEAR_LIMIT   = 3'd0;
    localparam cfg_idx_t REG_MIN_DISTANCE = 3'd1;
    localparam cfg_idx_t REG_SPREAD_LIMIT = 3'd2;
    localparam cfg_idx_t REG_SCALE_MULT   = 3'd3;
    localparam cfg_idx_t REG_SCALE_SHIFT  = 3'd4;

    localparam int COUNT_W    = 16;
    localparam int DIST_W     = 16;
    localparam int SHIFT_W    = 5;
    localparam int WIN_CNT_W  = 3;
    localparam int WINDOW_LEN = 6;

    localparam logic [DIST_W-1:0]  NEAR_LIMIT_RST   = 16'd20;
    localparam logic [DIST_W-1:0]  MIN_DISTANCE_RST = 16'd5;
    localparam logic [DIST_W-1:0]  SPREAD_LIMIT_RST = 16'd50;
    localparam logic [DIST_W-1:0]  SCALE_MULT_RST   = 16'd1130;
    localparam logic [SHIFT_W-1:0] SCALE_SHIFT_RST  = 5'd16;

endpackage
`default_nettype wire

### rtl/echo_trimmed_mean_ranger_top.sv
// echo trimmed-mean ranger: windowed max/min trimmed average, scaling and classification
// Takes one echo count per cycle unless m_ready stalls; one result word per input, in order.
// A nonzero count joins a window of six; on the sixth the largest and smallest are dropped,
// the other four are averaged, checked for spread, scaled by scale_mult >> scale_shift
// (saturated to 16 bits) and classified. A zero count clears the window and reports no echo.
// The path is two register stages (input register, result register) with the window state
// and the single multiplier between them; one word can enter every cycle while m_ready does
// not stall. Only the low SAMPLE_WIDTH bits of the count are used (at most 16). The user
// must write registers only while idle; the block itself does not enforce it.
`default_nettype none
module echo_trimmed_mean_ranger_top
    import etr_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [COUNT_W-1:0]    s_echo_count,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [2:0]                 m_status,
    output logic [DIST_W-1:0]          m_distance
);

    localparam int SW     = (SAMPLE_WIDTH < COUNT_W) ? SAMPLE_WIDTH : COUNT_W;
    localparam int SUM_W  = SW + 3;
    localparam int PROD_W = SW + DIST_W;
    localparam int LIM_W  = DIST_W + 1;
    localparam logic [WIN_CNT_W-1:0] LAST_SLOT = WIN_CNT_W'(WINDOW_LEN - 1);

    // configuration
    logic [DIST_W-1:0]  near_limit_reg;
    logic [DIST_W-1:0]  min_distance_reg;
    logic [DIST_W-1:0]  spread_limit_reg;
    logic [DIST_W-1:0]  scale_mult_reg;
    logic [SHIFT_W-1:0] scale_shift_reg;

    // pipeline
    logic          in_valid_reg;
    logic [SW-1:0] in_sample_reg;
    logic          out_valid_reg;
    status_t       status_reg;
    status_t       status_next;
    logic          out_free;
    logic          advance;

    // window state
    logic [WIN_CNT_W-1:0] sample_count_reg, sample_count_next;
    logic [SUM_W-1:0]     running_sum_reg, running_sum_next;
    logic [SW-1:0]        window_max_reg, window_max_next;
    logic [SW-1:0]        window_min_reg, window_min_next;
    logic                 have_first_reg, have_first_next;
    logic [DIST_W-1:0]    last_distance_reg, last_distance_next;

    logic [SW-1:0]     max_upd, min_upd;
    logic [SUM_W-1:0]  sum_upd;
    logic [SUM_W-1:0]  trimmed;
    logic [SW-1:0]     avg;
    logic [LIM_W-1:0]  spread_lim;
    logic              spread_ok;
    logic [PROD_W-1:0] product;
    logic [PROD_W-1:0] shifted;
    logic [DIST_W-1:0] scaled_dist;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign m_valid    = out_valid_reg;
    assign m_status   = status_reg;
    assign m_distance = last_distance_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_limit_reg   <= NEAR_LIMIT_RST;
            min_distance_reg <= MIN_DISTANCE_RST;
            spread_limit_reg <= SPREAD_LIMIT_RST;
            scale_mult_reg   <= SCALE_MULT_RST;
            scale_shift_reg  <= SCALE_SHIFT_RST;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_NEAR_LIMIT:   near_limit_reg   <= cfg_data;
                REG_MIN_DISTANCE: min_distance_reg <= cfg_data;
                REG_SPREAD_LIMIT: spread_limit_reg <= cfg_data;
                REG_SCALE_MULT:   scale_mult_reg   <= cfg_data;
                REG_SCALE_SHIFT:  scale_shift_reg  <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // window update and trimmed average
    always_comb begin
        if (!have_first_reg) begin
            max_upd = in_sample_reg;
            min_upd = in_sample_reg;
        end else begin
            max_upd = (in_sample_reg > window_max_reg) ? in_sample_reg : window_max_reg;
            min_upd = (in_sample_reg < window_min_reg) ? in_sample_reg : window_min_reg;
        end
        sum_upd     = running_sum_reg + SUM_W'(in_sample_reg);
        trimmed     = sum_upd - SUM_W'(max_upd) - SUM_W'(min_upd);
        avg         = trimmed[SW+1:2];
        spread_lim  = LIM_W'(min_upd) + LIM_W'(spread_limit_reg);
        spread_ok   = LIM_W'(max_upd) <= spread_lim;
        product     = PROD_W'(avg) * PROD_W'(scale_mult_reg);
        shifted     = product >> scale_shift_reg;
        scaled_dist = (|shifted[PROD_W-1:DIST_W]) ? {DIST_W{1'b1}} : shifted[DIST_W-1:0];
    end

    always_comb begin
        sample_count_next  = sample_count_reg;
        running_sum_next   = running_sum_reg;
        window_max_next    = window_max_reg;
        window_min_next    = window_min_reg;
        have_first_next    = have_first_reg;
        last_distance_next = last_distance_reg;
        status_next        = ST_PENDING;
        if (in_sample_reg == '0) begin
            sample_count_next = '0;
            running_sum_next  = '0;
            window_max_next   = '0;
            window_min_next   = '0;
            have_first_next   = 1'b0;
            status_next       = ST_NO_ECHO;
        end else if (sample_count_reg == LAST_SLOT) begin
            sample_count_next = '0;
            running_sum_next  = '0;
            window_max_next   = '0;
            window_min_next   = '0;
            have_first_next   = 1'b0;
            if (spread_ok) begin
                last_distance_next = scaled_dist;
                priority if (scaled_dist >= near_limit_reg) begin
                    status_next = ST_SAFE;
                end else if (scaled_dist >= min_distance_reg) begin
                    status_next = ST_CLOSE;
                end else begin
                    status_next = ST_BELOW;
                end
            end else begin
                status_next = ST_SPREAD;
            end
        end else begin
            sample_count_next = sample_count_reg + 1'b1;
            running_sum_next  = sum_upd;
            window_max_next   = max_upd;
            window_min_next   = min_upd;
            have_first_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            sample_count_reg  <= '0;
            running_sum_reg   <= '0;
            window_max_reg    <= '0;
            window_min_reg    <= '0;
            have_first_reg    <= 1'b0;
            last_distance_reg <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                sample_count_reg  <= sample_count_next;
                running_sum_reg   <= running_sum_next;
                window_max_reg    <= window_max_next;
                window_min_reg    <= window_min_next;
                have_first_reg    <= have_first_next;
                last_distance_reg <= last_distance_next;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_echo_count[SW-1:0];
        end
        if (advance) begin
            status_reg <= status_next;
        end
    end

endmodule
`default_nettype wire
